### rtl/device_presence_aging_table_unit_macros.svh
// Assertion macros for the device presence aging table.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef DEVICE_PRESENCE_AGING_TABLE_UNIT_MACROS_SVH
`define DEVICE_PRESENCE_AGING_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPAT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DPAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dpat_pkg.sv
// Shared types and constants for the device presence aging table.
// No dependencies.
package dpat_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned OCTET_W     = 8;
  localparam int unsigned OCTET_SPAN  = 256;
  localparam int unsigned DEPTH_DEF   = 256;
  localparam logic [TIME_W-1:0] LOST_TIMEOUT_RST = 32'd3000;

  typedef enum logic {
    CMD_BEACON = 1'b0,
    CMD_CHECK  = 1'b1
  } cmd_t;

  typedef enum logic {
    EVT_FOUND = 1'b0,
    EVT_LOST  = 1'b1
  } evt_kind_t;

  typedef struct packed {
    logic              evt_vld;
    evt_kind_t         evt_kind;
    logic [ADDR_W-1:0] evt_addr;
    logic              addr_we;
    logic [ADDR_W-1:0] new_addr;
    logic              stamp_we;
    logic [TIME_W-1:0] new_stamp;
  } upd_t;

endpackage

### rtl/dpat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/dpat_update.sv
// Entry update logic: beacon compare/refresh and age check against timeout.
// Depends on dpat_pkg.
module dpat_update (
  input  logic                          vld,
  input  dpat_pkg::cmd_t                cmd,
  input  logic [dpat_pkg::ADDR_W-1:0]   src_addr,
  input  logic [dpat_pkg::TIME_W-1:0]   now_time,
  input  logic [dpat_pkg::TIME_W-1:0]   lost_timeout,
  input  logic [dpat_pkg::ADDR_W-1:0]   cur_addr,
  input  logic [dpat_pkg::TIME_W-1:0]   cur_stamp,
  output dpat_pkg::upd_t                upd
);

  logic [dpat_pkg::TIME_W-1:0] limit;
  logic                        expired;

  assign limit   = cur_stamp + lost_timeout;
  assign expired = (cur_addr != '0) && (limit < now_time);

  always_comb begin
    upd           = '0;
    upd.evt_kind  = dpat_pkg::EVT_FOUND;
    upd.new_stamp = cur_stamp;
    case (cmd)
      dpat_pkg::CMD_BEACON: begin
        upd.evt_vld   = vld && (cur_addr != src_addr);
        upd.evt_kind  = dpat_pkg::EVT_FOUND;
        upd.evt_addr  = src_addr;
        upd.addr_we   = vld;
        upd.new_addr  = src_addr;
        upd.stamp_we  = vld;
        upd.new_stamp = now_time;
      end
      dpat_pkg::CMD_CHECK: begin
        upd.evt_vld  = vld && expired;
        upd.evt_kind = dpat_pkg::EVT_LOST;
        upd.evt_addr = cur_addr;
        upd.addr_we  = vld && expired;
        upd.new_addr = '0;
      end
      default: begin
        upd.evt_vld = 1'b0;
      end
    endcase
  end

endmodule

### rtl/device_presence_aging_table_unit.sv
// Top level of the device presence aging table: slot mapping, table RAMs,
// forwarding, update stage and result register.
// Depends on dpat_pkg, dpat_ram, dpat_update and the assertion macro header.
//
//  channel  | handshake              | word
//  ---------+------------------------+----------------------------------------
//  in       | start, busy            | cmd, src_addr, entry_index, now_time
//  out      | out_strobe             | event_kind, device_addr
//  cfg      | cfg_valid, cfg_ready   | lost_timeout
//
// One word per cycle: busy stays low, the RAM read is registered together
// with the stage-1 registers, and the combinational update feeds the result
// register that drives the ports. A write-to-read forwarding register covers
// back-to-back words on the same entry.
// Reset clears the per-entry valid bits at once, no sweep.
// The receiver cannot stall; cfg_ready is always high.
`include "device_presence_aging_table_unit_macros.svh"

module device_presence_aging_table_unit #(
  parameter int unsigned TABLE_DEPTH = dpat_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_cmd,
  input  logic [dpat_pkg::ADDR_W-1:0]     in_src_addr,
  input  logic [dpat_pkg::OCTET_W-1:0]    in_entry_index,
  input  logic [dpat_pkg::TIME_W-1:0]     in_now_time,
  output logic                            out_strobe,
  output logic                            out_event_kind,
  output logic [dpat_pkg::ADDR_W-1:0]     out_device_addr,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpat_pkg::TIME_W-1:0]     cfg_data
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  function automatic logic [dpat_pkg::OCTET_SPAN-1:0][IdxW-1:0] build_slot_lut();
    logic [dpat_pkg::OCTET_SPAN-1:0][IdxW-1:0] lut;
    int unsigned cnt;
    cnt = 0;
    for (int unsigned i = 0; i < dpat_pkg::OCTET_SPAN; i++) begin
      lut[i] = IdxW'(cnt);
      cnt    = (cnt + 1 == TABLE_DEPTH) ? 0 : cnt + 1;
    end
    return lut;
  endfunction

  localparam logic [dpat_pkg::OCTET_SPAN-1:0][IdxW-1:0] SLOT_LUT = build_slot_lut();

  logic [dpat_pkg::TIME_W-1:0] lost_timeout_r;
  logic                        accept;
  logic [IdxW-1:0]             rd_idx;

  logic                        s1_vld_r;
  dpat_pkg::cmd_t              s1_cmd_r;
  logic [dpat_pkg::ADDR_W-1:0] s1_src_r;
  logic [dpat_pkg::TIME_W-1:0] s1_now_r;
  logic [IdxW-1:0]             s1_idx_r;

  logic [TABLE_DEPTH-1:0]      ent_vld_r;
  logic [TABLE_DEPTH-1:0]      ent_vld_nxt;

  logic                        byp_vld_r;
  logic [IdxW-1:0]             byp_idx_r;
  logic [dpat_pkg::ADDR_W-1:0] byp_addr_r;
  logic [dpat_pkg::TIME_W-1:0] byp_stamp_r;

  logic [dpat_pkg::ADDR_W-1:0] ram_addr_q;
  logic [dpat_pkg::TIME_W-1:0] ram_stamp_q;
  logic [dpat_pkg::ADDR_W-1:0] cur_addr;
  logic [dpat_pkg::TIME_W-1:0] cur_stamp;
  logic                        byp_hit;
  logic                        ent_wr;
  dpat_pkg::upd_t              upd;

  logic                        out_strobe_r;
  logic                        out_event_kind_r;
  logic [dpat_pkg::ADDR_W-1:0] out_device_addr_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign rd_idx = (dpat_pkg::cmd_t'(in_cmd) == dpat_pkg::CMD_CHECK)
                ? SLOT_LUT[in_entry_index] : SLOT_LUT[in_src_addr[dpat_pkg::OCTET_W-1:0]];

  dpat_ram #(
    .WIDTH (dpat_pkg::ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_addr_ram (
    .clk   (clk),
    .we    (upd.addr_we),
    .waddr (s1_idx_r),
    .wdata (upd.new_addr),
    .raddr (rd_idx),
    .rdata (ram_addr_q)
  );

  dpat_ram #(
    .WIDTH (dpat_pkg::TIME_W),
    .DEPTH (TABLE_DEPTH)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (upd.stamp_we),
    .waddr (s1_idx_r),
    .wdata (upd.new_stamp),
    .raddr (rd_idx),
    .rdata (ram_stamp_q)
  );

  assign byp_hit = byp_vld_r && (byp_idx_r == s1_idx_r);

  always_comb begin
    if (byp_hit) begin
      cur_addr  = byp_addr_r;
      cur_stamp = byp_stamp_r;
    end else if (ent_vld_r[s1_idx_r]) begin
      cur_addr  = ram_addr_q;
      cur_stamp = ram_stamp_q;
    end else begin
      cur_addr  = '0;
      cur_stamp = '0;
    end
  end

  dpat_update u_update (
    .vld          (s1_vld_r),
    .cmd          (s1_cmd_r),
    .src_addr     (s1_src_r),
    .now_time     (s1_now_r),
    .lost_timeout (lost_timeout_r),
    .cur_addr     (cur_addr),
    .cur_stamp    (cur_stamp),
    .upd          (upd)
  );

  assign ent_wr = upd.addr_we || upd.stamp_we;

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    if (ent_wr) begin
      ent_vld_nxt[s1_idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_timeout_r <= dpat_pkg::LOST_TIMEOUT_RST;
      s1_vld_r       <= 1'b0;
      ent_vld_r      <= '0;
      byp_vld_r      <= 1'b0;
      out_strobe_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lost_timeout_r <= cfg_data;
      end
      s1_vld_r     <= accept;
      ent_vld_r    <= ent_vld_nxt;
      byp_vld_r    <= ent_wr;
      out_strobe_r <= upd.evt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r <= dpat_pkg::cmd_t'(in_cmd);
      s1_src_r <= in_src_addr;
      s1_now_r <= in_now_time;
      s1_idx_r <= rd_idx;
    end
    byp_idx_r   <= s1_idx_r;
    byp_addr_r  <= upd.addr_we ? upd.new_addr : cur_addr;
    byp_stamp_r <= upd.new_stamp;
    if (upd.evt_vld) begin
      out_event_kind_r  <= upd.evt_kind;
      out_device_addr_r <= upd.evt_addr;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_event_kind  = out_event_kind_r;
  assign out_device_addr = out_device_addr_r;

  `DPAT_ASSERT_IMPL(a_strobe_from_item, out_strobe_r, $past(s1_vld_r), "result without item")
  `DPAT_ASSERT_IMPL(a_lost_nonzero, out_strobe_r && (out_event_kind_r == dpat_pkg::EVT_LOST), out_device_addr_r != '0, "lost event with empty address")
  `DPAT_ASSERT_IMPL(a_byp_marks_valid, byp_vld_r, ent_vld_r[byp_idx_r], "written entry not marked valid")
  `DPAT_ASSERT_NEXT(a_write_forwards, ent_wr, byp_vld_r && (byp_idx_r == $past(s1_idx_r)), "write not forwarded")

endmodule
